// ----- sv/tgc_pkg.sv -----
// Shared constants for the touch gesture classifier: event codes, register indexes, defaults.
package tgc_pkg;

    // Coordinate width used as the default for the top-level parameter.
    localparam int COORD_BITS_DEFAULT = 12;

    // Widths of the event code field, the configuration port, the timestamp and the hold time.
    localparam int EVENT_BITS    = 4;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int TIME_BITS     = 32;
    localparam int HOLD_BITS     = 16;

    // Event codes reported on the result stream.
    localparam logic [EVENT_BITS-1:0] EV_NONE        = 4'd0;
    localparam logic [EVENT_BITS-1:0] EV_DRAG        = 4'd1;
    localparam logic [EVENT_BITS-1:0] EV_LONG        = 4'd2;
    localparam logic [EVENT_BITS-1:0] EV_HOLD_END    = 4'd3;
    localparam logic [EVENT_BITS-1:0] EV_BACK        = 4'd4;
    localparam logic [EVENT_BITS-1:0] EV_SWIPE_RIGHT = 4'd5;
    localparam logic [EVENT_BITS-1:0] EV_UP          = 4'd6;
    localparam logic [EVENT_BITS-1:0] EV_DOWN        = 4'd7;
    localparam logic [EVENT_BITS-1:0] EV_TAP         = 4'd8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_DRAG_START = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SWIPE_MIN  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_PRESS = 2'd2;

    // Register reset values.
    localparam int DRAG_START_RESET = 12;
    localparam int SWIPE_MIN_RESET  = 40;
    localparam int LONG_PRESS_RESET = 500;

endpackage

// ----- sv/touch_gesture_classifier_core.sv -----
// Touch gesture classifier: input register, one-pass classification, result register.
// A sample transferred into the input register is classified into the result register
// once that register is empty or its result is taken. Throughput: one sample per cycle
// while m_tready allows; the gesture state updates in the same cycle the result register
// loads, so samples follow back to back. Reset (rst_n low, asynchronous) clears both
// valid flags and the gesture state and restores the thresholds.
module touch_gesture_classifier_core #(
    parameter int COORD_BITS = tgc_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Sample stream. tdata: x_pos, y_pos, time_ms (lowest first). tuser: pressed.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((2*COORD_BITS+32+7)/8)*8-1:0] s_tdata,
    input  logic                                s_tuser,
    // Result stream. tdata: out_x, out_y (lowest first). tuser: event_code.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((2*COORD_BITS+2+7)/8)*8-1:0] m_tdata,
    output logic [tgc_pkg::EVENT_BITS-1:0]      m_tuser,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tgc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [tgc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import tgc_pkg::*;

    localparam int CB       = COORD_BITS;
    localparam int OUT_BITS = ((2*CB+2+7)/8)*8;
    localparam int IN_USED  = 2*CB + TIME_BITS;
    localparam int OUT_USED = 2*CB + 2;

    // Threshold registers.
    logic [CB-1:0]        drag_start_reg;
    logic [CB-1:0]        swipe_min_reg;
    logic [HOLD_BITS-1:0] long_press_reg;

    // Input register.
    logic                 in_valid_reg;
    logic                 in_pressed_reg;
    logic [CB-1:0]        in_x_reg;
    logic [CB-1:0]        in_y_reg;
    logic [TIME_BITS-1:0] in_time_reg;

    // Result register.
    logic                  out_valid_reg;
    logic [EVENT_BITS-1:0] out_event_reg;
    logic [CB:0]           out_x_reg;
    logic [CB:0]           out_y_reg;

    // Gesture state.
    logic                 finger_down_reg;
    logic [CB-1:0]        start_x_reg;
    logic [CB-1:0]        start_y_reg;
    logic [TIME_BITS-1:0] start_time_reg;
    logic                 long_fired_reg;
    logic                 drag_active_reg;
    logic [CB-1:0]        last_drag_y_reg;

    logic                 finger_down_next;
    logic [CB-1:0]        start_x_next;
    logic [CB-1:0]        start_y_next;
    logic [TIME_BITS-1:0] start_time_next;
    logic                 long_fired_next;
    logic                 drag_active_next;
    logic [CB-1:0]        last_drag_y_next;
    logic [EVENT_BITS-1:0] event_next;
    logic [CB:0]           res_x_next;
    logic [CB:0]           res_y_next;

    logic                 s_fire;
    logic                 advance;
    logic                 in_valid_next;
    logic                 out_valid_next;

    logic signed [CB:0]   dx;
    logic signed [CB:0]   dy;
    logic signed [CB:0]   dx_abs_wide;
    logic signed [CB:0]   dy_abs_wide;
    logic [CB-1:0]        adx;
    logic [CB-1:0]        ady;
    logic [CB:0]          step;
    logic [CB-1:0]        drag_ref_y;
    logic                 drag_now;
    logic                 moved;
    logic [TIME_BITS-1:0] held_ms;

    // Handshake and pipeline advance.
    assign s_fire    = s_tvalid && s_tready;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign in_valid_next  = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    // Outputs.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_event_reg;
    assign m_tdata  = {{(OUT_BITS-OUT_USED){1'b0}}, out_y_reg, out_x_reg};

    // Travel from the touchdown point and its magnitudes.
    assign dx = $signed({1'b0, in_x_reg}) - $signed({1'b0, start_x_reg});
    assign dy = $signed({1'b0, in_y_reg}) - $signed({1'b0, start_y_reg});
    assign dx_abs_wide = dx[CB] ? -dx : dx;
    assign dy_abs_wide = dy[CB] ? -dy : dy;
    assign adx = dx_abs_wide[CB-1:0];
    assign ady = dy_abs_wide[CB-1:0];
    assign moved   = (adx > swipe_min_reg) || (ady > swipe_min_reg);
    assign held_ms = in_time_reg - start_time_reg;

    // A drag starts on a mostly vertical travel at or past the drag threshold, unless a long press fired.
    assign drag_now   = !drag_active_reg && !long_fired_reg &&
                        (ady >= drag_start_reg) && (ady > adx);
    assign drag_ref_y = drag_now ? in_y_reg : last_drag_y_reg;
    assign step       = {1'b0, in_y_reg} - {1'b0, drag_ref_y};

    // Classification of the sample in the input register.
    always_comb
    begin
        finger_down_next = finger_down_reg;
        start_x_next     = start_x_reg;
        start_y_next     = start_y_reg;
        start_time_next  = start_time_reg;
        long_fired_next  = long_fired_reg;
        drag_active_next = drag_active_reg;
        last_drag_y_next = last_drag_y_reg;
        event_next       = EV_NONE;
        res_x_next       = '0;
        res_y_next       = '0;

        if (in_pressed_reg && !finger_down_reg)
        begin
            // Touchdown records the start point and time and clears the gesture flags; no event.
            finger_down_next = 1'b1;
            start_x_next     = in_x_reg;
            start_y_next     = in_y_reg;
            start_time_next  = in_time_reg;
            long_fired_next  = 1'b0;
            drag_active_next = 1'b0;
        end
        else if (finger_down_reg)
        begin
            if (in_pressed_reg)
            begin
                if (drag_active_reg || drag_now)
                begin
                    drag_active_next = 1'b1;
                    last_drag_y_next = drag_ref_y;
                    if (step != '0)
                    begin
                        last_drag_y_next = in_y_reg;
                        event_next       = EV_DRAG;
                        res_y_next       = step;
                    end
                end
                else if (!long_fired_reg && !moved &&
                         (held_ms >= {{(TIME_BITS-HOLD_BITS){1'b0}}, long_press_reg}))
                begin
                    long_fired_next = 1'b1;
                    event_next      = EV_LONG;
                    res_x_next      = {1'b0, start_x_reg};
                    res_y_next      = {1'b0, start_y_reg};
                end
            end
            else
            begin
                // Lift: release, end of drag, swipe or tap.
                finger_down_next = 1'b0;
                if (long_fired_reg)
                begin
                    event_next = EV_HOLD_END;
                end
                else if (drag_active_reg)
                begin
                    drag_active_next = 1'b0;
                end
                else if ((adx >= swipe_min_reg) && (adx > ady))
                begin
                    event_next = dx[CB] ? EV_BACK : EV_SWIPE_RIGHT;
                    res_x_next = dx;
                    res_y_next = dy;
                end
                else if ((ady >= swipe_min_reg) && (ady > adx))
                begin
                    event_next = dy[CB] ? EV_UP : EV_DOWN;
                    res_x_next = dx;
                    res_y_next = dy;
                end
                else
                begin
                    event_next = EV_TAP;
                    res_x_next = {1'b0, in_x_reg};
                    res_y_next = {1'b0, in_y_reg};
                end
            end
        end
    end

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drag_start_reg <= CB'(DRAG_START_RESET);
            swipe_min_reg  <= CB'(SWIPE_MIN_RESET);
            long_press_reg <= HOLD_BITS'(LONG_PRESS_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DRAG_START: drag_start_reg <= cfg_data[CB-1:0];
                CFG_SWIPE_MIN:  swipe_min_reg  <= cfg_data[CB-1:0];
                CFG_LONG_PRESS: long_press_reg <= cfg_data[HOLD_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // Pipeline valid flags and gesture state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            finger_down_reg <= 1'b0;
            start_x_reg     <= '0;
            start_y_reg     <= '0;
            start_time_reg  <= '0;
            long_fired_reg  <= 1'b0;
            drag_active_reg <= 1'b0;
            last_drag_y_reg <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                finger_down_reg <= finger_down_next;
                start_x_reg     <= start_x_next;
                start_y_reg     <= start_y_next;
                start_time_reg  <= start_time_next;
                long_fired_reg  <= long_fired_next;
                drag_active_reg <= drag_active_next;
                last_drag_y_reg <= last_drag_y_next;
            end
        end
    end

    // Input and result payload registers.
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_pressed_reg <= s_tuser;
            in_x_reg       <= s_tdata[CB-1:0];
            in_y_reg       <= s_tdata[2*CB-1:CB];
            in_time_reg    <= s_tdata[IN_USED-1:2*CB];
        end
        if (advance)
        begin
            out_event_reg <= event_next;
            out_x_reg     <= res_x_next;
            out_y_reg     <= res_y_next;
        end
    end

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the touch gesture classifier core.
`timescale 1ns / 1ps

module testbench;
    import tgc_pkg::*;

    localparam int CW          = COORD_BITS_DEFAULT;
    localparam int SD_W        = ((2*CW+32+7)/8)*8;
    localparam int MD_W        = ((2*CW+2+7)/8)*8;
    localparam int OW          = CW + 1;
    localparam int CMAX        = (1 << CW) - 1;
    localparam int STALL_LIMIT = 5000;

    typedef struct {
        logic                 pressed;
        logic [CW-1:0]        x;
        logic [CW-1:0]        y;
        logic [TIME_BITS-1:0] t;
    } sample_t;

    typedef struct {
        logic [EVENT_BITS-1:0] code;
        logic [OW-1:0]         ox;
        logic [OW-1:0]         oy;
    } gesture_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [SD_W-1:0]          s_tdata = '0;
    logic                     s_tuser = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [MD_W-1:0]          m_tdata;
    logic [EVENT_BITS-1:0]    m_tuser;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    // Samples waiting to be sent and events waiting to come back.
    sample_t  samples_to_send[$];
    gesture_t expected_events[$];
    sample_t  offered;
    gesture_t arrived;

    int            errors = 0;
    int            quiet_cycles = 0;
    int            hold_off = 0;
    bit            gaps_on = 1'b1;
    logic [31:0]   clock_ms = '0;

    // Predictor copy of the threshold registers.
    logic [CW-1:0]        drag_px = CW'(DRAG_START_RESET);
    logic [CW-1:0]        swipe_px = CW'(SWIPE_MIN_RESET);
    logic [HOLD_BITS-1:0] hold_ms = HOLD_BITS'(LONG_PRESS_RESET);

    // Predictor copy of the gesture state.
    logic                 touching = 1'b0;
    logic [CW-1:0]        down_x = '0;
    logic [CW-1:0]        down_y = '0;
    logic [TIME_BITS-1:0] down_t = '0;
    logic                 long_done = 1'b0;
    logic                 dragging = 1'b0;
    logic [CW-1:0]        drag_y = '0;

    touch_gesture_classifier_core #(
        .COORD_BITS(CW)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // Works out the gesture event for one sample and advances the gesture state.
    function automatic gesture_t classify_sample(sample_t s);
        gesture_t             g;
        int                   dx;
        int                   dy;
        int                   adx;
        int                   ady;
        int                   step;
        logic [TIME_BITS-1:0] held;
        g.code = EV_NONE;
        g.ox   = '0;
        g.oy   = '0;
        if (s.pressed && !touching)
        begin
            touching  = 1'b1;
            down_x    = s.x;
            down_y    = s.y;
            down_t    = s.t;
            long_done = 1'b0;
            dragging  = 1'b0;
            return g;
        end
        if (!touching)
            return g;
        dx  = int'(s.x) - int'(down_x);
        dy  = int'(s.y) - int'(down_y);
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        if (s.pressed)
        begin
            if (!dragging && !long_done && ady >= int'(drag_px) && ady > adx)
            begin
                dragging = 1'b1;
                drag_y   = s.y;
            end
            if (dragging)
            begin
                step = int'(s.y) - int'(drag_y);
                if (step != 0)
                begin
                    drag_y = s.y;
                    g.code = EV_DRAG;
                    g.oy   = step[OW-1:0];
                end
                return g;
            end
            // Elapsed time wraps with the timestamp.
            held = s.t - down_t;
            if (!long_done && !(adx > int'(swipe_px) || ady > int'(swipe_px)) &&
                held >= TIME_BITS'(hold_ms))
            begin
                long_done = 1'b1;
                g.code    = EV_LONG;
                g.ox      = {1'b0, down_x};
                g.oy      = {1'b0, down_y};
            end
            return g;
        end
        // Finger lifted.
        touching = 1'b0;
        if (long_done)
            g.code = EV_HOLD_END;
        else if (dragging)
            dragging = 1'b0;
        else if (adx >= int'(swipe_px) && adx > ady)
        begin
            g.code = (dx < 0) ? EV_BACK : EV_SWIPE_RIGHT;
            g.ox   = dx[OW-1:0];
            g.oy   = dy[OW-1:0];
        end
        else if (ady >= int'(swipe_px) && ady > adx)
        begin
            g.code = (dy < 0) ? EV_UP : EV_DOWN;
            g.ox   = dx[OW-1:0];
            g.oy   = dy[OW-1:0];
        end
        else
        begin
            g.code = EV_TAP;
            g.ox   = {1'b0, s.x};
            g.oy   = {1'b0, s.y};
        end
        return g;
    endfunction

    task automatic report_mismatch(string what, int want_v, int got_v);
        $display("mismatch on %s: expected %0h, got %0h at %0t", what, want_v, got_v, $time);
        errors++;
    endtask

    function automatic int clamp(int v);
        return (v < 0) ? 0 : ((v > CMAX) ? CMAX : v);
    endfunction

    function automatic int jitter(int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    function automatic void add_sample(bit p, int x, int y, logic [TIME_BITS-1:0] t);
        sample_t s;
        s.pressed = p;
        s.x       = x[CW-1:0];
        s.y       = y[CW-1:0];
        s.t       = t;
        samples_to_send.push_back(s);
    endfunction

    // Queues one random gesture (or a few noise samples) and returns the sample count.
    function automatic int add_gesture();
        int kind;
        int n;
        int x;
        int y;
        int x0;
        int y0;
        int moves;
        int reach;
        int d;
        int i;
        kind = $urandom_range(0, 9);
        x0   = $urandom_range(0, CMAX);
        y0   = $urandom_range(0, CMAX);
        if (kind >= 8)
        begin
            n = $urandom_range(1, 4);
            repeat (n)
                add_sample($urandom_range(0, 1) == 1, $urandom_range(0, CMAX),
                           $urandom_range(0, CMAX), $urandom());
            return n;
        end
        add_sample(1'b1, x0, y0, clock_ms);
        moves = (kind < 5) ? $urandom_range(0, 6) : 0;
        reach = $urandom_range(0, int'(swipe_px) + 2);
        x = x0;
        y = y0;
        for (i = 0; i < moves; i++)
        begin
            clock_ms += $urandom_range(0, int'(hold_ms) / 2 + 20);
            if (kind < 3)
            begin
                // Finger resting near the touchdown point.
                x = clamp(x0 + jitter(reach));
                y = clamp(y0 + jitter(reach));
            end
            else
            begin
                // Mostly vertical travel.
                x = clamp(x + jitter(2));
                y = clamp(y + jitter(int'(drag_px) + 8));
            end
            add_sample(1'b1, x, y, clock_ms);
        end
        if (kind == 5 || kind == 6)
        begin
            x = clamp(x0 + jitter(2 * int'(swipe_px) + 50));
            y = clamp(y0 + jitter(2 * int'(swipe_px) + 50));
        end
        else if (kind == 7)
        begin
            // Diagonal lift with equal travel on both axes.
            d = $urandom_range(0, int'(swipe_px) + 10);
            x = clamp(x0 + (($urandom_range(0, 1) == 1) ? d : -d));
            y = clamp(y0 + (($urandom_range(0, 1) == 1) ? d : -d));
        end
        clock_ms += $urandom_range(0, int'(hold_ms) / 2 + 20);
        add_sample(1'b0, x, y, clock_ms);
        return moves + 2;
    endfunction

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_BITS-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_DRAG_START: drag_px  = value[CW-1:0];
            CFG_SWIPE_MIN:  swipe_px = value[CW-1:0];
            CFG_LONG_PRESS: hold_ms  = value[HOLD_BITS-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (samples_to_send.size() != 0 || s_tvalid || expected_events.size() != 0);
    endtask

    task automatic run_phase(int drag, int swipe, int hold, int count, bit gaps, int stall);
        int queued;
        queued = 0;
        write_reg(CFG_DRAG_START, drag);
        write_reg(CFG_SWIPE_MIN, swipe);
        write_reg(CFG_LONG_PRESS, hold);
        gaps_on  = gaps;
        hold_off = stall;
        clock_ms = $urandom();
        while (queued < count)
            queued += add_gesture();
        wait_drained();
    endtask

    // Sample driver: a new transfer is offered once the previous one completes.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_events.push_back(classify_sample(offered));
            if (!s_tvalid || s_tready)
            begin
                if (samples_to_send.size() > 0 && !(gaps_on && $urandom_range(0, 99) < 20))
                begin
                    offered = samples_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {offered.t, offered.y, offered.x};
                    s_tuser  <= offered.pressed;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls plus an occasional long hold-off.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_off > 0)
            begin
                hold_off = hold_off - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !(gaps_on && $urandom_range(0, 99) < 20);
        end
    end

    // Result monitor: each transfer is checked against the oldest predicted event.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_events.size() == 0)
                report_mismatch("unexpected result, event_code", 0, int'(m_tuser));
            else
            begin
                arrived = expected_events.pop_front();
                if (m_tuser !== arrived.code)
                    report_mismatch("event_code", int'(arrived.code), int'(m_tuser));
                if (m_tdata[OW-1:0] !== arrived.ox)
                    report_mismatch("out_x", int'(arrived.ox), int'(m_tdata[OW-1:0]));
                if (m_tdata[2*OW-1:OW] !== arrived.oy)
                    report_mismatch("out_y", int'(arrived.oy), int'(m_tdata[2*OW-1:OW]));
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed samples at the reset thresholds.
        // Lift with no finger down.
        add_sample(1'b0, 0, 0, 0);
        // Hold still at the origin: one tick short of the hold time, then on it.
        add_sample(1'b1, 0, 0, 0);
        add_sample(1'b1, 0, 0, 499);
        add_sample(1'b1, 0, 0, 500);
        add_sample(1'b0, 0, 0, 950);
        // Hold across the timestamp wrap at the far corner, travel left at the limit.
        add_sample(1'b1, CMAX, CMAX, 32'hFFFF_FFFF);
        add_sample(1'b1, CMAX - 40, CMAX, 32'h0000_01F3);
        add_sample(1'b0, CMAX, CMAX, 32'h0000_0200);
        // Vertical drag: start with no step, a step, a zero step, a step back.
        add_sample(1'b1, 2000, 2000, 100);
        add_sample(1'b1, 2000, 2012, 110);
        add_sample(1'b1, 2003, 2030, 120);
        add_sample(1'b1, 2003, 2030, 130);
        add_sample(1'b1, 2000, 1990, 140);
        add_sample(1'b0, 2000, 1990, 150);
        // Swipes in all four directions, full width where possible.
        add_sample(1'b1, 0, 100, 0);
        add_sample(1'b0, CMAX, 100, 10);
        add_sample(1'b1, CMAX, 0, 0);
        add_sample(1'b0, 0, 10, 10);
        add_sample(1'b1, 0, CMAX, 0);
        add_sample(1'b0, 5, 0, 10);
        add_sample(1'b1, 50, 50, 0);
        add_sample(1'b0, 60, 150, 10);
        // Equal travel on both axes falls back to a tap.
        add_sample(1'b1, 500, 500, 0);
        add_sample(1'b0, 560, 440, 10);
        // Travel just past the swipe threshold blocks the long press.
        add_sample(1'b1, 1000, 1000, 0);
        add_sample(1'b1, 1041, 1000, 600);
        add_sample(1'b0, 1041, 1000, 700);
        wait_drained();

        // Random gestures under several threshold settings.
        run_phase(DRAG_START_RESET, SWIPE_MIN_RESET, LONG_PRESS_RESET, 140, 1'b1, 0);
        run_phase(0, 0, 0, 120, 1'b0, 0);
        run_phase(CMAX, CMAX, 65535, 120, 1'b1, 0);
        run_phase($urandom_range(1, 200), $urandom_range(1, 300), $urandom_range(1, 3000),
                  150, 1'b1, 0);
        run_phase($urandom_range(1, 200), $urandom_range(1, 300), $urandom_range(1, 3000),
                  150, 1'b1, 0);
        // Back-pressure: the receiver holds off while samples keep coming.
        run_phase(DRAG_START_RESET, SWIPE_MIN_RESET, LONG_PRESS_RESET, 60, 1'b0, 80);

        repeat (10) @(negedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
